// File: rtl/psal_pkg.sv
`timescale 1ns / 1ps
package psal_pkg;

    localparam int LOGIT_W  = 16;
    localparam int LABEL_W  = 8;
    localparam int CONF_W   = 16;
    localparam int SUM_W    = 24;
    localparam int E_W      = 17;
    localparam int QUO_W    = 33;
    localparam int DSTEP_W  = 6;

    localparam logic [LABEL_W-1:0] NO_LABEL     = 8'hFF;
    localparam logic [CONF_W-1:0]  CONF_RESET   = 16'h8000;
    localparam logic [SUM_W-1:0]   SUM_ONE      = 24'h010000;
    localparam logic [SUM_W-1:0]   SUM_MAX      = 24'hFFFFFF;
    localparam logic [DSTEP_W-1:0] DIV_STEPS    = 6'd33;

    typedef struct packed {
        logic load;      // capture item, look up exp term
        logic update;    // fold item into running state
        logic div_init;  // start 2^32 / exp_sum
        logic div_step;  // one quotient bit
        logic out_load;  // move result to output register, clear pixel
    } t_cmd;

    typedef struct packed {
        logic last;
        logic div_done;
        logic out_full;
    } t_sts;

endpackage

// File: rtl/psal_ctrl.sv
`timescale 1ns / 1ps
module psal_ctrl
    import psal_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_DINIT,
        S_DSTEP,
        S_DOUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.last ? S_DINIT : S_IDLE;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DSTEP;
            end
            S_DSTEP: begin
                if (i_sts.div_done) begin
                    n_state = S_DOUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DOUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_UPD)
        else $error("load did not move to update");
    a_div_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSTEP && i_sts.div_done) |=> r_state == S_DOUT)
        else $error("divider finish not followed by output");
    a_upd_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |=> !o_cmd.update)
        else $error("back to back updates");

endmodule

// File: rtl/psal_dp.sv
`timescale 1ns / 1ps
module psal_dp
    import psal_pkg::*;
#(
    parameter int MAX_CHANNELS   = 255,
    parameter int EXP_TABLE_SIZE = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic signed [LOGIT_W-1:0] i_logit,
    input  logic                      i_last,
    input  logic                      i_cfg_we,
    input  logic [CONF_W-1:0]         i_cfg_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [LABEL_W-1:0]        o_label,
    output logic [CONF_W-1:0]         o_conf
);

    localparam int IDX_W = $clog2(EXP_TABLE_SIZE);
    localparam int PROD_W = 29;

    typedef logic [E_W-1:0] t_tbl [EXP_TABLE_SIZE];

    // exp(-16 i / N) in Q1.16, powers of r kept in Q1.32
    function automatic t_tbl f_build();
        t_tbl        t;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] p;
        x    = (64'd16 << 32) / EXP_TABLE_SIZE;
        term = 64'd1 << 32;
        r    = term;
        p    = 64'd1 << 32;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * x) >> 32) / 64'(k);
            if (k % 2 == 1) r = r - term;
            else            r = r + term;
        end
        for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
            t[i] = E_W'((p + 64'd32768) >> 16);
            p    = (p * r) >> 32;
        end
        return t;
    endfunction

    localparam t_tbl EXP_TBL = f_build();

    logic [CONF_W-1:0]         r_thr;
    logic signed [LOGIT_W-1:0] r_max;
    logic [LABEL_W-1:0]        r_best;
    logic [SUM_W-1:0]          r_sum;
    logic [7:0]                r_cnt;
    logic signed [LOGIT_W-1:0] r_v;
    logic                      r_last;
    logic                      r_gt;
    logic [E_W-1:0]            r_e;
    logic [QUO_W-1:0]          r_quo;
    logic [SUM_W:0]            r_rem;
    logic [DSTEP_W-1:0]        r_dcnt;
    logic                      r_out_valid;
    logic [LABEL_W-1:0]        r_label;
    logic [CONF_W-1:0]         r_conf;

    // lookup from the incoming logit against the current maximum
    logic signed [LOGIT_W:0] diff;
    logic                    gt;
    logic [LOGIT_W-1:0]      d;
    logic [PROD_W-1:0]       idx_prod;
    logic [16:0]             idx;
    logic                    idx_oor;

    assign diff     = 17'(i_logit) - 17'(r_max);
    assign gt       = i_logit > r_max;
    assign d        = gt ? diff[LOGIT_W-1:0] : LOGIT_W'(-diff);
    assign idx_prod = PROD_W'(d) * PROD_W'(EXP_TABLE_SIZE);
    assign idx      = idx_prod[PROD_W-1:12];
    assign idx_oor  = idx >= 17'(EXP_TABLE_SIZE);

    // running state update
    logic [SUM_W+E_W:0] scaled;
    logic [SUM_W+E_W:0] grow;
    logic [SUM_W:0]     add;

    assign scaled = (SUM_W+E_W+1)'(r_sum) * (SUM_W+E_W+1)'(r_e) + (SUM_W+E_W+1)'(32768);
    assign grow   = (scaled >> 16) + (SUM_W+E_W+1)'(SUM_ONE);
    assign add    = (SUM_W+1)'(r_sum) + (SUM_W+1)'(r_e);

    // restoring divide, one quotient bit per step
    logic [SUM_W+1:0] trial;
    assign trial = {r_rem, r_quo[QUO_W-1]} - {2'b00, r_sum};

    logic [CONF_W-1:0] conf;
    always_comb begin
        if (r_sum == '0) conf = '0;
        else if (r_quo > QUO_W'(16'hFFFF)) conf = 16'hFFFF;
        else conf = r_quo[CONF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v    <= i_logit;
            r_last <= i_last;
            r_gt   <= gt;
            r_e    <= idx_oor ? '0 : EXP_TBL[idx[IDX_W-1:0]];
        end
        if (i_cmd.div_init) begin
            r_quo  <= QUO_W'(64'd1 << 32);
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
            if (!trial[SUM_W+1]) begin
                r_rem <= trial[SUM_W:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[SUM_W-1:0], r_quo[QUO_W-1]};
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_conf  <= conf;
            r_label <= (conf >= r_thr) ? r_best : NO_LABEL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= CONF_RESET;
            r_max       <= {1'b1, {(LOGIT_W-1){1'b0}}};
            r_best      <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_thr <= i_cfg_data;
            if (i_cmd.update && (32'(r_cnt) < MAX_CHANNELS)) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '0) begin
                    r_max  <= r_v;
                    r_best <= '0;
                    r_sum  <= SUM_ONE;
                end else if (r_gt) begin
                    r_max  <= r_v;
                    r_best <= r_cnt;
                    r_sum  <= (grow > (SUM_W+E_W+1)'(SUM_MAX)) ? SUM_MAX : grow[SUM_W-1:0];
                end else begin
                    r_sum  <= add[SUM_W] ? SUM_MAX : add[SUM_W-1:0];
                end
            end
            if (i_cmd.out_load) begin
                r_max       <= {1'b1, {(LOGIT_W-1){1'b0}}};
                r_best      <= '0;
                r_sum       <= '0;
                r_cnt       <= '0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.div_done = r_dcnt == DIV_STEPS;
    assign o_sts.out_full = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_label        = r_label;
    assign o_conf         = r_conf;

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (r_cnt == '0 && r_sum == '0))
        else $error("pixel state not cleared after result");
    a_cnt_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_CHANNELS)
        else $error("channel count past limit");
    a_sum_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_sum >= SUM_ONE))
        else $error("exp sum below one inside a pixel");

endmodule

// File: rtl/pixel_softmax_argmax_label_unit.sv
`timescale 1ns / 1ps
// Non-final channel item: accept + table term, then state update.
// Final channel item: accept, state update, divider init, the 33 steps of
// the one-bit-per-cycle 2^32 / exp_sum divider, a state that sees it done,
// then the result load. A result still waiting on the output stretches this.
// New items are taken while a result waits on the output register.
// Reset (i_rst_n low, synchronous): threshold 32768, pixel state cleared.
module pixel_softmax_argmax_label_unit
    import psal_pkg::*;
#(
    parameter int MAX_CHANNELS   = 255,
    parameter int EXP_TABLE_SIZE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] logit
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] label, [23:8] confidence
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    t_cmd              cmd;
    t_sts              sts;
    logic [LABEL_W-1:0] label;
    logic [CONF_W-1:0]  conf;

    psal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    psal_dp #(
        .MAX_CHANNELS   (MAX_CHANNELS),
        .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_logit     (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_cfg_we    (i_cfg_wr_en),
        .i_cfg_data  (i_cfg_wr_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_label     (label),
        .o_conf      (conf)
    );

    assign m_axis_tdata = {conf, label};

endmodule

// File: test/pixel_softmax_argmax_label_unit_test.sv
`timescale 1ns / 1ps
module pixel_softmax_argmax_label_unit_test
    import psal_pkg::*;
;

    localparam int N_CH     = 255;
    localparam int TBL_SIZE = 256;
    localparam longint CYCLE_LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] logit
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [7:0] label, [23:8] confidence
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;

    pixel_softmax_argmax_label_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data)
    );

    typedef struct packed {
        logic [CONF_W-1:0]  conf;
        logic [LABEL_W-1:0] label;
    } t_pixel_result;

    t_pixel_result pixel_results_q[$];
    logic [16:0]   exp_tbl [TBL_SIZE];
    logic [15:0]   threshold;
    logic signed [15:0] run_max;
    logic [7:0]    win_ch;
    logic [23:0]   sum_acc;
    logic [7:0]    ch_cnt;
    int            fail_count;
    longint        cycle_count;
    bit            out_idle_en;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pixel_softmax_argmax_label_unit test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic void build_exp_table();
        logic [63:0] x, term, r, p;
        x = (64'd16 << 32) / TBL_SIZE;
        term = 64'd1 << 32;
        r = term;
        p = 64'd1 << 32;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * x) >> 32) / k;
            if (k % 2) r = r - term;
            else r = r + term;
        end
        for (int i = 0; i < TBL_SIZE; i++) begin
            exp_tbl[i] = 17'((p + 64'd32768) >> 16);
            p = (p * r) >> 32;
        end
    endfunction

    function automatic logic [16:0] exp_term(input logic [15:0] d);
        longint idx;
        idx = (longint'(d) * TBL_SIZE) >> 12;
        return (idx >= TBL_SIZE) ? 17'd0 : exp_tbl[idx];
    endfunction

    function automatic void clear_pixel();
        run_max = 16'sh8000;
        win_ch = '0;
        sum_acc = '0;
        ch_cnt = '0;
    endfunction

    // fold one channel; queue a result on the pixel end
    function automatic void predict_channel(input logic [15:0] logit, input logic last);
        logic signed [15:0] v;
        logic [63:0] s;
        logic [63:0] q;
        t_pixel_result res;
        v = logit;
        if (ch_cnt < N_CH) begin
            if (ch_cnt == 0) begin
                run_max = v;
                win_ch = '0;
                sum_acc = SUM_ONE;
            end else if (v > run_max) begin
                s = ((64'(sum_acc) * exp_term(16'(v - run_max)) + 64'd32768) >> 16) + 64'd65536;
                sum_acc = (s > 64'hFFFFFF) ? SUM_MAX : s[23:0];
                run_max = v;
                win_ch = ch_cnt;
            end else begin
                s = 64'(sum_acc) + exp_term(16'(run_max - v));
                sum_acc = (s > 64'hFFFFFF) ? SUM_MAX : s[23:0];
            end
            ch_cnt++;
        end
        if (last) begin
            if (sum_acc == 0) res.conf = '0;
            else begin
                q = (64'd1 << 32) / sum_acc;
                res.conf = (q > 65535) ? 16'hFFFF : q[15:0];
            end
            res.label = (res.conf >= threshold) ? win_ch : NO_LABEL;
            pixel_results_q = {pixel_results_q, res};
            clear_pixel();
        end
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // valid stays up after the handshake until the next item or a drain
    task automatic send_channel(input logic [15:0] logit, input logic last);
        int g;
        g = gap_len();
        if (g != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= logit;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_channel(logit, last);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pixel_results_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [15:0] val);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        threshold = val;
    endtask

    // result check
    initial begin
        t_pixel_result exp_res, got;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pixel_results_q.size() == 0)
                    report_mismatch($sformatf("unexpected item %h", m_axis_tdata));
                else begin
                    exp_res = pixel_results_q.pop_front();
                    if (got.label !== exp_res.label)
                        report_mismatch($sformatf("label %0d exp %0d",
                            got.label, exp_res.label));
                    if (got.conf !== exp_res.conf)
                        report_mismatch($sformatf("confidence %0d exp %0d",
                            got.conf, exp_res.conf));
                end
            end
        end
    end

    // receiver stalls
    initial begin
        int g;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!out_idle_en) m_axis_tready <= 1'b1;
            else begin
                g = gap_len();
                if (g == 0) m_axis_tready <= 1'b1;
                else begin
                    m_axis_tready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    task automatic send_pixel(input int n_ch, input int spread);
        logic [15:0] v;
        for (int c = 0; c < n_ch; c++) begin
            if (spread == 0) v = 16'($urandom);
            else v = 16'($urandom_range(0, 2 * spread) - spread);
            send_channel(v, c == n_ch - 1);
        end
    endtask

    task automatic test_directed();
        send_channel(16'h1234, 1'b1);                    // single channel
        send_channel(16'h8000, 1'b0);                    // extremes
        send_channel(16'h7FFF, 1'b1);
        send_channel(16'h7FFF, 1'b0);
        send_channel(16'h8000, 1'b1);
        send_channel(16'h0100, 1'b0);                    // tie, first wins
        send_channel(16'h0100, 1'b1);
        send_channel(16'h0000, 1'b0);                    // rising max
        send_channel(16'h0080, 1'b0);
        send_channel(16'h0200, 1'b0);
        send_channel(16'hFF00, 1'b1);
        send_channel(16'hFFFF, 1'b0);
        send_channel(16'hFFFF, 1'b0);
        send_channel(16'hFFFF, 1'b1);
    endtask

    task automatic test_thresholds();
        write_threshold(16'hFFFF);
        send_channel(16'h0055, 1'b1);                    // 1.0 passes max threshold
        send_pixel(3, 64);
        write_threshold(16'h0000);
        send_pixel(4, 0);
        send_pixel(5, 300);
        write_threshold(16'h0001);
        send_pixel(8, 100);
    endtask

    task automatic test_channel_overflow();
        write_threshold(16'h0000);
        send_pixel(255, 40);
        send_pixel(270, 40);                             // extra channels ignored
    endtask

    task automatic test_random();
        int sent, n;
        sent = 0;
        while (sent < 1170) begin
            if ($urandom_range(0, 19) == 0) begin
                drain_results();                         // sender holds off
                write_threshold(16'($urandom));
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0: send_pixel(n, 0);
                1: send_pixel(n, 16);
                2: send_pixel(n, 256);
                default: send_pixel(n, 2048);
            endcase
            sent += n;
        end
    endtask

    initial begin
        cycle_count   = 0;
        fail_count    = 0;
        out_idle_en   = 1'b1;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        build_exp_table();
        threshold = CONF_RESET;
        clear_pixel();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_thresholds();
        test_channel_overflow();
        out_idle_en = 1'b0;
        send_pixel(20, 100);
        out_idle_en = 1'b1;
        test_random();
        drain_results();
        if (fail_count == 0)
            $display("pixel_softmax_argmax_label_unit test passed");
        else
            $display("pixel_softmax_argmax_label_unit test failed");
        $finish;
    end

endmodule
